[src/sam_pkg.sv]
// Shared constants, codes and a helper function for the suffix automaton matcher.
package sam_pkg;

  // Default text capacity in symbols.
  localparam int unsigned MaxText = 4096;

  // Symbol alphabet and field widths.
  localparam int unsigned Alphabet = 26;
  localparam int unsigned SymW     = 5;
  localparam int unsigned OpW      = 2;

  // Request operation codes.
  typedef enum logic [OpW-1:0] {
    OpClear  = 2'd0,
    OpAppend = 2'd1,
    OpMatch  = 2'd2,
    OpNone   = 2'd3
  } op_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    StIdle,
    StAppLast,
    StAppWalk,
    StAppQ,
    StAppCopy,
    StAppRedir,
    StAppDone,
    StMatch,
    StRes,
    StResOut
  } state_e;

  // Lowest symbol whose bit is set in an edge mask, zero when none is set.
  function automatic logic [SymW-1:0] lowest_sym(input logic [Alphabet-1:0] mask);
    logic [SymW-1:0] r;
    r = '0;
    for (int k = Alphabet - 1; k >= 0; k--) begin
      if (mask[k]) begin
        r = SymW'(k);
      end
    end
    return r;
  endfunction

endpackage

[src/sam_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module sam_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read; read data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/suffix_automaton_matcher.sv]
// Suffix automaton builder and streaming query matcher, top level.
//
//   channel  dir  handshake              payload
//   in       in   in_valid_i/in_ready_o  op_i, symbol_i, restart_match_i
//   out      out  out_valid_o/out_ready_i match_length_o, match_node_o,
//                                        can_extend_o, extend_symbol_o, full_res_o
//
// One request is worked at a time by a sequencer around two memories: a
// transition memory (one target per node and symbol) and a node memory holding
// length, suffix link and an edge mask per node. A match follows suffix links
// until an edge is found; an append walks suffix links and may clone a node,
// copying all of its edges one symbol at a time.
// The root lives in flip-flops, so reset and clear take effect at once, with
// no clearing pass. A new request is taken while the last result still waits
// at the output register; the final step stalls until that register is free.
module suffix_automaton_matcher #(
  parameter int unsigned MAX_TEXT = sam_pkg::MaxText,
  localparam int unsigned MaxNodes = 2 * MAX_TEXT,
  localparam int unsigned NodeW    = $clog2(MaxNodes),
  localparam int unsigned LenW     = $clog2(MAX_TEXT + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [sam_pkg::OpW-1:0]   op_i,
  input  logic [sam_pkg::SymW-1:0]  symbol_i,
  input  logic                      restart_match_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [LenW-1:0]           match_length_o,
  output logic [NodeW-1:0]          match_node_o,
  output logic                      can_extend_o,
  output logic [sam_pkg::SymW-1:0]  extend_symbol_o,
  output logic                      full_res_o
);

  localparam int unsigned Alpha      = sam_pkg::Alphabet;
  localparam int unsigned SymW       = sam_pkg::SymW;
  localparam int unsigned CntW       = NodeW + 1;
  localparam int unsigned TransDepth = MaxNodes * Alpha;
  localparam int unsigned TaW        = $clog2(TransDepth);
  localparam int unsigned KW         = $clog2(Alpha + 1);
  localparam int unsigned EntW       = Alpha + NodeW + LenW;

  typedef struct packed {
    logic [Alpha-1:0] mask;
    logic [NodeW-1:0] link;
    logic [LenW-1:0]  len;
  } node_t;

  // Transition memory address of one node and symbol.
  function automatic logic [TaW-1:0] taddr(input logic [NodeW-1:0] node,
                                           input logic [SymW-1:0] sym);
    return TaW'(node) * TaW'(Alpha) + TaW'(sym);
  endfunction

  sam_pkg::state_e state_q, state_d;
  logic [SymW-1:0]  sym_q, sym_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [NodeW-1:0] last_q, last_d;
  logic [NodeW-1:0] cnode_q, cnode_d;
  logic [LenW-1:0]  clen_q, clen_d;
  logic [Alpha-1:0] root_mask_q, root_mask_d;
  logic [NodeW-1:0] p_q, p_d;
  logic [NodeW-1:0] cur_q, cur_d;
  logic [NodeW-1:0] qn_q, qn_d;
  logic [NodeW-1:0] cl_q, cl_d;
  logic [KW-1:0]    k_q, k_d;
  logic [LenW-1:0]  curlen_q, curlen_d;
  logic             full_q, full_d;
  logic             walked_q, walked_d;
  logic             rd_root_q;
  node_t            pent_q, pent_d;
  node_t            qent_q, qent_d;

  logic             out_valid_q, out_valid_d;
  logic [LenW-1:0]  out_len_q, out_len_d;
  logic [NodeW-1:0] out_node_q, out_node_d;
  logic             out_can_q, out_can_d;
  logic [SymW-1:0]  out_ext_q, out_ext_d;
  logic             out_full_q, out_full_d;

  // Memory ports.
  logic             nm_we, nm_re;
  logic [NodeW-1:0] nm_waddr, nm_raddr;
  node_t            nm_wdata;
  logic [EntW-1:0]  nm_rdata;
  logic             tm_we, tm_re;
  logic [TaW-1:0]   tm_waddr, tm_raddr;
  logic [NodeW-1:0] tm_wdata, tm_rdata;

  node_t            nd;
  logic [LenW-1:0]  base_len;
  logic             in_acc;

  sam_ram #(.WIDTH(EntW), .DEPTH(MaxNodes)) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (nm_we),
    .waddr_i (nm_waddr),
    .wdata_i (nm_wdata),
    .re_i    (nm_re),
    .raddr_i (nm_raddr),
    .rdata_o (nm_rdata)
  );

  sam_ram #(.WIDTH(NodeW), .DEPTH(TransDepth)) u_trans_ram (
    .clk_i   (clk_i),
    .we_i    (tm_we),
    .waddr_i (tm_waddr),
    .wdata_i (tm_wdata),
    .re_i    (tm_re),
    .raddr_i (tm_raddr),
    .rdata_o (tm_rdata)
  );

  // The root entry is held in flip-flops and overrides the node memory.
  always_comb begin
    if (rd_root_q) begin
      nd.mask = root_mask_q;
      nd.link = '0;
      nd.len  = '0;
    end else begin
      nd = node_t'(nm_rdata);
    end
  end

  assign in_ready_o = (state_q == sam_pkg::StIdle);
  assign in_acc     = in_valid_i & in_ready_o;
  assign base_len   = walked_q ? nd.len : clen_q;

  // Next state, memory accesses and register updates.
  always_comb begin
    state_d     = state_q;
    sym_d       = sym_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    cnode_d     = cnode_q;
    clen_d      = clen_q;
    root_mask_d = root_mask_q;
    p_d         = p_q;
    cur_d       = cur_q;
    qn_d        = qn_q;
    cl_d        = cl_q;
    k_d         = k_q;
    curlen_d    = curlen_q;
    full_d      = full_q;
    walked_d    = walked_q;
    pent_d      = pent_q;
    qent_d      = qent_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_len_d   = out_len_q;
    out_node_d  = out_node_q;
    out_can_d   = out_can_q;
    out_ext_d   = out_ext_q;
    out_full_d  = out_full_q;
    nm_we       = 1'b0;
    nm_waddr    = '0;
    nm_wdata    = '0;
    nm_re       = 1'b0;
    nm_raddr    = '0;
    tm_we       = 1'b0;
    tm_waddr    = '0;
    tm_wdata    = '0;
    tm_re       = 1'b0;
    tm_raddr    = '0;

    case (state_q)
      sam_pkg::StIdle: begin
        if (in_acc) begin
          sym_d    = symbol_i;
          full_d   = 1'b0;
          walked_d = 1'b0;
          case (sam_pkg::op_e'(op_i))
            sam_pkg::OpClear: begin
              cnt_d       = CntW'(1);
              last_d      = '0;
              cnode_d     = '0;
              clen_d      = '0;
              root_mask_d = '0;
              state_d     = sam_pkg::StRes;
            end
            sam_pkg::OpAppend: begin
              if (symbol_i < SymW'(Alpha)) begin
                nm_re    = 1'b1;
                nm_raddr = last_q;
                state_d  = sam_pkg::StAppLast;
              end else begin
                state_d = sam_pkg::StRes;
              end
            end
            sam_pkg::OpMatch: begin
              if (restart_match_i || symbol_i >= SymW'(Alpha)) begin
                cnode_d = '0;
                clen_d  = '0;
              end
              if (symbol_i < SymW'(Alpha)) begin
                nm_re    = 1'b1;
                nm_raddr = restart_match_i ? '0 : cnode_q;
                tm_re    = 1'b1;
                tm_raddr = taddr(nm_raddr, symbol_i);
                state_d  = sam_pkg::StMatch;
              end else begin
                state_d = sam_pkg::StRes;
              end
            end
            default: begin
              state_d = sam_pkg::StRes;
            end
          endcase
        end
      end

      // Capacity check, then create the new node and start the link walk.
      sam_pkg::StAppLast: begin
        if (nd.len >= LenW'(MAX_TEXT) || cnt_q + CntW'(2) > CntW'(MaxNodes)) begin
          full_d  = 1'b1;
          state_d = sam_pkg::StRes;
        end else begin
          cur_d         = cnt_q[NodeW-1:0];
          cnt_d         = cnt_q + CntW'(1);
          curlen_d      = nd.len + LenW'(1);
          nm_we         = 1'b1;
          nm_waddr      = cnt_q[NodeW-1:0];
          nm_wdata.mask = '0;
          nm_wdata.link = '0;
          nm_wdata.len  = nd.len + LenW'(1);
          p_d           = last_q;
          nm_re         = 1'b1;
          nm_raddr      = last_q;
          tm_re         = 1'b1;
          tm_raddr      = taddr(last_q, sym_q);
          state_d       = sam_pkg::StAppWalk;
        end
      end

      // Add edges to the new node along suffix links until one exists or the root is reached.
      sam_pkg::StAppWalk: begin
        pent_d = nd;
        if (nd.mask[sym_q]) begin
          qn_d     = tm_rdata;
          nm_re    = 1'b1;
          nm_raddr = tm_rdata;
          state_d  = sam_pkg::StAppQ;
        end else begin
          tm_we    = 1'b1;
          tm_waddr = taddr(p_q, sym_q);
          tm_wdata = cur_q;
          if (p_q == '0) begin
            root_mask_d[sym_q] = 1'b1;
            state_d            = sam_pkg::StAppDone;
          end else begin
            nm_we              = 1'b1;
            nm_waddr           = p_q;
            nm_wdata           = nd;
            nm_wdata.mask[sym_q] = 1'b1;
            p_d                = nd.link;
            nm_re              = 1'b1;
            nm_raddr           = nd.link;
            tm_re              = 1'b1;
            tm_raddr           = taddr(nd.link, sym_q);
          end
        end
      end

      // Solid edge links directly; otherwise clone the target node.
      sam_pkg::StAppQ: begin
        nm_we = 1'b1;
        if (pent_q.len + LenW'(1) == nd.len) begin
          nm_waddr      = cur_q;
          nm_wdata.mask = '0;
          nm_wdata.link = qn_q;
          nm_wdata.len  = curlen_q;
          state_d       = sam_pkg::StAppDone;
        end else begin
          cl_d          = cnt_q[NodeW-1:0];
          cnt_d         = cnt_q + CntW'(1);
          qent_d        = nd;
          nm_waddr      = cnt_q[NodeW-1:0];
          nm_wdata.mask = nd.mask;
          nm_wdata.link = nd.link;
          nm_wdata.len  = pent_q.len + LenW'(1);
          k_d           = '0;
          state_d       = sam_pkg::StAppCopy;
        end
      end

      // Copy the target's edges to the clone, one symbol per cycle, and link the target and new node to the clone.
      sam_pkg::StAppCopy: begin
        if (k_q < KW'(Alpha)) begin
          tm_re    = 1'b1;
          tm_raddr = taddr(qn_q, k_q[SymW-1:0]);
        end
        if (k_q != '0) begin
          tm_we    = 1'b1;
          tm_waddr = taddr(cl_q, SymW'(k_q - KW'(1)));
          tm_wdata = tm_rdata;
        end
        if (k_q == KW'(0)) begin
          nm_we         = 1'b1;
          nm_waddr      = qn_q;
          nm_wdata.mask = qent_q.mask;
          nm_wdata.link = cl_q;
          nm_wdata.len  = qent_q.len;
        end else if (k_q == KW'(1)) begin
          nm_we         = 1'b1;
          nm_waddr      = cur_q;
          nm_wdata.mask = '0;
          nm_wdata.link = cl_q;
          nm_wdata.len  = curlen_q;
        end
        if (k_q == KW'(Alpha)) begin
          nm_re    = 1'b1;
          nm_raddr = p_q;
          tm_re    = 1'b1;
          tm_raddr = taddr(p_q, sym_q);
          state_d  = sam_pkg::StAppRedir;
        end else begin
          k_d = k_q + KW'(1);
        end
      end

      // Redirect edges that pointed at the old target to the clone.
      sam_pkg::StAppRedir: begin
        if (nd.mask[sym_q] && tm_rdata == qn_q) begin
          tm_we    = 1'b1;
          tm_waddr = taddr(p_q, sym_q);
          tm_wdata = cl_q;
          if (p_q == '0) begin
            state_d = sam_pkg::StAppDone;
          end else begin
            p_d      = nd.link;
            nm_re    = 1'b1;
            nm_raddr = nd.link;
            tm_re    = 1'b1;
            tm_raddr = taddr(nd.link, sym_q);
          end
        end else begin
          state_d = sam_pkg::StAppDone;
        end
      end

      sam_pkg::StAppDone: begin
        last_d  = cur_q;
        state_d = sam_pkg::StRes;
      end

      // Follow suffix links until the cursor has an edge or reaches the root.
      sam_pkg::StMatch: begin
        if (nd.mask[sym_q]) begin
          cnode_d = tm_rdata;
          clen_d  = base_len + LenW'(1);
          state_d = sam_pkg::StRes;
        end else if (cnode_q == '0) begin
          clen_d  = '0;
          state_d = sam_pkg::StRes;
        end else begin
          cnode_d  = nd.link;
          walked_d = 1'b1;
          nm_re    = 1'b1;
          nm_raddr = nd.link;
          tm_re    = 1'b1;
          tm_raddr = taddr(nd.link, sym_q);
        end
      end

      sam_pkg::StRes: begin
        nm_re    = 1'b1;
        nm_raddr = cnode_q;
        state_d  = sam_pkg::StResOut;
      end

      // Load the result register once it is free.
      sam_pkg::StResOut: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_len_d   = clen_q;
          out_node_d  = cnode_q;
          out_can_d   = |nd.mask;
          out_ext_d   = sam_pkg::lowest_sym(nd.mask);
          out_full_d  = full_q;
          state_d     = sam_pkg::StIdle;
        end
      end

      default: begin
        state_d = sam_pkg::StIdle;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sam_pkg::StIdle;
      cnt_q       <= CntW'(1);
      last_q      <= '0;
      cnode_q     <= '0;
      clen_q      <= '0;
      root_mask_q <= '0;
      out_valid_q <= 1'b0;
      rd_root_q   <= 1'b1;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      last_q      <= last_d;
      cnode_q     <= cnode_d;
      clen_q      <= clen_d;
      root_mask_q <= root_mask_d;
      out_valid_q <= out_valid_d;
      if (nm_re) begin
        rd_root_q <= (nm_raddr == '0);
      end
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk_i) begin
    sym_q      <= sym_d;
    p_q        <= p_d;
    cur_q      <= cur_d;
    qn_q       <= qn_d;
    cl_q       <= cl_d;
    k_q        <= k_d;
    curlen_q   <= curlen_d;
    full_q     <= full_d;
    walked_q   <= walked_d;
    pent_q     <= pent_d;
    qent_q     <= qent_d;
    out_len_q  <= out_len_d;
    out_node_q <= out_node_d;
    out_can_q  <= out_can_d;
    out_ext_q  <= out_ext_d;
    out_full_q <= out_full_d;
  end

  assign out_valid_o     = out_valid_q;
  assign match_length_o  = out_len_q;
  assign match_node_o    = out_node_q;
  assign can_extend_o    = out_can_q;
  assign extend_symbol_o = out_ext_q;
  assign full_res_o      = out_full_q;

  // The node count never passes the node memory depth.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxNodes))
    else $error("node count beyond capacity");

  // Between requests, a cursor at the root always carries length zero.
  a_root_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sam_pkg::StIdle && cnode_q == '0) |-> (clen_q == '0))
    else $error("root cursor with nonzero length");

  // No node memory read meets a write to the same entry in one cycle.
  a_nm_rw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nm_we && nm_re) |-> (nm_waddr != nm_raddr))
    else $error("node memory read and write collide");

  // No transition memory read meets a write to the same entry in one cycle.
  a_tm_rw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tm_we && tm_re) |-> (tm_waddr != tm_raddr))
    else $error("transition memory read and write collide");

  // The root entry is never written into the node memory.
  a_root_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nm_we |-> (nm_waddr != '0))
    else $error("root written to node memory");

endmodule
